>>> sv/i2c3d_pkg.sv
// constants and register map of the 3d im2col descriptor generator
// used by: i2c3d_div, im2col_3d_address_generator_core, im2col_3d_checker, tb_im2col_3d_address_generator_core
package i2c3d_pkg;

	localparam int EXTENT_BITS_DEF = 12;
	localparam int TAP_BITS_DEF    = 4;
	localparam int ADDR_BITS_DEF   = 32;

	localparam int CH_BITS       = 12;
	localparam int IMG_BITS      = 36;
	localparam int PACK_BITS     = 12;
	localparam int LEN_BITS      = 12;
	localparam int CFG_DATA_BITS = 36;
	localparam int CFG_IDX_BITS  = 3;
	localparam int DIVISOR_BITS  = 12;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CHANNELS    = 3'd0,
		REG_GROUPS      = 3'd1,
		REG_IMAGE_SIZE  = 3'd2,
		REG_KERNEL_SIZE = 3'd3,
		REG_DILATION    = 3'd4,
		REG_STRIDE      = 3'd5,
		REG_PAD_BEFORE  = 3'd6,
		REG_PAD_AFTER   = 3'd7
	} cfg_reg_t;

	localparam logic [CH_BITS-1:0]   CHANNELS_RST = 12'd1;
	localparam logic [CH_BITS-1:0]   GROUPS_RST   = 12'd1;
	localparam logic [IMG_BITS-1:0]  IMAGE_RST    = 36'h001001001;
	localparam logic [PACK_BITS-1:0] TRIPLE_ONE   = 12'h111;
	localparam logic [PACK_BITS-1:0] PAD_RST      = 12'h000;

	// handshake between the sequencer and the divider
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
		logic busy;
	} div_sts_t;

endpackage

>>> sv/i2c3d_div.sv
// restoring divider, one quotient bit per cycle
// depends on: i2c3d_pkg (control and status structs)
module i2c3d_div #(
	parameter int NUM_BITS = 14,
	parameter int DEN_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i2c3d_pkg::div_ctl_t   ctl,
	input  logic [NUM_BITS-1:0]   dividend,
	input  logic [DEN_BITS-1:0]   divisor,
	output i2c3d_pkg::div_sts_t   sts,
	output logic [NUM_BITS-1:0]   quotient
);

	localparam int CNT_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] dvs_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   trial;
	logic                fits;

	assign trial = {rem_q, quo_q[NUM_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(NUM_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the dividend shifts out of the top of quo_q while quotient bits enter below
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_BITS'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DEN_BITS-1:0];
			end
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;

endmodule

>>> sv/im2col_3d_address_generator_core.sv
// 3d nhwc im2col descriptor generator, one descriptor per request transaction
// per active request: a divider pass for channels per group, then 20 multiply-add
// steps; a new request is taken only when idle, once the last descriptor has been
// registered, which waits for a free output; a restart first runs a span step and a
// divider pass per axis for the output extents (none for an empty axis); done skips both
// reset: asynchronous, active low; configuration registers take their defaults, no run active
module im2col_3d_address_generator_core #(
	parameter int EXTENT_BITS = i2c3d_pkg::EXTENT_BITS_DEF,
	parameter int TAP_BITS    = i2c3d_pkg::TAP_BITS_DEF,
	parameter int ADDR_BITS   = i2c3d_pkg::ADDR_BITS_DEF,
	localparam int IN_W  = ((1 + 2 * ADDR_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * ADDR_BITS + i2c3d_pkg::LEN_BITS + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [i2c3d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [i2c3d_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [IN_W-1:0]                      s_axis_tdata,  // func, src_base, dst_base
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [OUT_W-1:0]                     m_axis_tdata,  // src_addr, dst_addr, length
	output logic                                 m_axis_tlast,
	output logic [1:0]                           m_axis_tuser   // fill_zero, done_res
);

	localparam int E     = EXTENT_BITS;
	localparam int T     = TAP_BITS;
	localparam int A     = ADDR_BITS;
	localparam int CB    = i2c3d_pkg::CH_BITS;
	localparam int LB    = i2c3d_pkg::LEN_BITS;
	localparam int UW0   = (E + T + 2 > 2 * T + 2) ? E + T + 2 : 2 * T + 2;
	localparam int UW    = (A > UW0) ? A : UW0;
	localparam int MB    = (E > CB) ? E : CB;
	localparam int GW    = MB;
	localparam int NUMW  = ((E > T + 1) ? E : T + 1) + 2;
	localparam int DIVW  = (NUMW > CB) ? NUMW : CB;
	localparam int DVB   = i2c3d_pkg::DIVISOR_BITS;
	localparam int SPW   = 2 * T + 1;
	localparam int SW    = ((NUMW > SPW) ? NUMW : SPW) + 1;
	localparam int IMG3  = 3 * E;
	localparam int TAP3  = 3 * T;
	localparam logic [E-1:0] EXT_MAX = {E{1'b1}};

	// multiply-add program, one step per cycle
	localparam logic [4:0] OP_CT0  = 5'd0;
	localparam logic [4:0] OP_CT1  = 5'd1;
	localparam logic [4:0] OP_CH0  = 5'd2;
	localparam logic [4:0] OP_CH1  = 5'd3;
	localparam logic [4:0] OP_CW0  = 5'd4;
	localparam logic [4:0] OP_CW1  = 5'd5;
	localparam logic [4:0] OP_S0   = 5'd6;
	localparam logic [4:0] OP_S1   = 5'd7;
	localparam logic [4:0] OP_S2   = 5'd8;
	localparam logic [4:0] OP_S3   = 5'd9;
	localparam logic [4:0] OP_D0   = 5'd10;
	localparam logic [4:0] OP_D1   = 5'd11;
	localparam logic [4:0] OP_D2   = 5'd12;
	localparam logic [4:0] OP_D3   = 5'd13;
	localparam logic [4:0] OP_P0   = 5'd14;
	localparam logic [4:0] OP_P1   = 5'd15;
	localparam logic [4:0] OP_P2   = 5'd16;
	localparam logic [4:0] OP_P3   = 5'd17;
	localparam logic [4:0] OP_P4   = 5'd18;
	localparam logic [4:0] OP_P5   = 5'd19;
	localparam logic [4:0] OP_SPAN = 5'd20;

	localparam logic [2:0] DST_ACC = 3'd0;
	localparam logic [2:0] DST_CR0 = 3'd1;
	localparam logic [2:0] DST_CR1 = 3'd2;
	localparam logic [2:0] DST_CR2 = 3'd3;
	localparam logic [2:0] DST_TMP = 3'd4;
	localparam logic [2:0] DST_SRC = 3'd5;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SPAN   = 8'b0000_0010,
		S_NUM    = 8'b0000_0100,
		S_EXTDIV = 8'b0000_1000,
		S_CHECK  = 8'b0001_0000,
		S_CPG    = 8'b0010_0000,
		S_MAC    = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	// configuration registers
	logic [CB-1:0]                     channels_q;
	logic [CB-1:0]                     groups_q;
	logic [i2c3d_pkg::IMG_BITS-1:0]    image_q;
	logic [i2c3d_pkg::PACK_BITS-1:0]   kernel_q;
	logic [i2c3d_pkg::PACK_BITS-1:0]   dil_q;
	logic [i2c3d_pkg::PACK_BITS-1:0]   stride_q;
	logic [i2c3d_pkg::PACK_BITS-1:0]   padb_q;
	logic [i2c3d_pkg::PACK_BITS-1:0]   pada_q;

	state_t          state_q;
	logic [4:0]      op_q;
	logic [1:0]      axis_q;
	logic            func_q;
	logic [A-1:0]    src_base_q;
	logic [A-1:0]    dst_base_q;
	logic            run_active_q;
	logic [E-1:0]    ext_q [3];
	logic [E-1:0]    pos_q [3];
	logic [T-1:0]    tap_q [3];
	logic [E-1:0]    grp_idx_q;
	logic [LB-1:0]   cpg_q;
	logic [UW-1:0]   acc_q;
	logic [UW-1:0]   tmp_q;
	logic [UW-1:0]   src_q;
	logic [UW-1:0]   cr_q [3];

	logic            m_valid_q;
	logic [A-1:0]    m_src_q;
	logic [A-1:0]    m_dst_q;
	logic [LB-1:0]   m_len_q;
	logic            m_fill_q;
	logic            m_last_q;
	logic            m_done_q;

	// unpacked register fields, axis 0 = w, 1 = h, 2 = t
	logic [IMG3-1:0] img_x;
	logic [TAP3-1:0] ker_x, dil_x, str_x, pb_x, pa_x;
	logic [E-1:0]    n_f [3];
	logic [T-1:0]    k_f [3];
	logic [T-1:0]    d_f [3];
	logic [T-1:0]    s_f [3];
	logic [T-1:0]    pb_f [3];
	logic [T-1:0]    pa_f [3];
	logic [GW-1:0]   grp;

	always_comb begin
		img_x = IMG3'(image_q);
		ker_x = TAP3'(kernel_q);
		dil_x = TAP3'(dil_q);
		str_x = TAP3'(stride_q);
		pb_x  = TAP3'(padb_q);
		pa_x  = TAP3'(pada_q);
		for (int i = 0; i < 3; i++) begin
			n_f[i]  = img_x[i*E +: E];
			k_f[i]  = ker_x[i*T +: T];
			d_f[i]  = dil_x[i*T +: T];
			s_f[i]  = (str_x[i*T +: T] == '0) ? T'(1) : str_x[i*T +: T];
			pb_f[i] = pb_x[i*T +: T];
			pa_f[i] = pa_x[i*T +: T];
		end
		grp = (groups_q == '0) ? GW'(1) : GW'(groups_q);
	end

	// shared multiply-add unit: mac = a * b + c, wrapping
	logic [4:0]       op_sel;
	logic [UW-1:0]    mac_a;
	logic [MB-1:0]    mac_b;
	logic [UW-1:0]    mac_c;
	logic [2:0]       mac_dst;
	logic [UW+MB-1:0] mac_prod;
	logic [UW-1:0]    mac_res;

	assign op_sel = (state_q == S_SPAN) ? OP_SPAN : op_q;

	always_comb begin
		mac_a   = '0;
		mac_b   = '0;
		mac_c   = '0;
		mac_dst = DST_ACC;
		case (op_sel)
			OP_CT0: begin
				mac_a = UW'(tap_q[2]); mac_b = MB'(d_f[2]);
				mac_c = UW'(0) - UW'(pb_f[2]); mac_dst = DST_CR2;
			end
			OP_CT1: begin
				mac_a = UW'(pos_q[2]); mac_b = MB'(s_f[2]);
				mac_c = cr_q[2]; mac_dst = DST_CR2;
			end
			OP_CH0: begin
				mac_a = UW'(tap_q[1]); mac_b = MB'(d_f[1]);
				mac_c = UW'(0) - UW'(pb_f[1]); mac_dst = DST_CR1;
			end
			OP_CH1: begin
				mac_a = UW'(pos_q[1]); mac_b = MB'(s_f[1]);
				mac_c = cr_q[1]; mac_dst = DST_CR1;
			end
			OP_CW0: begin
				mac_a = UW'(tap_q[0]); mac_b = MB'(d_f[0]);
				mac_c = UW'(0) - UW'(pb_f[0]); mac_dst = DST_CR0;
			end
			OP_CW1: begin
				mac_a = UW'(pos_q[0]); mac_b = MB'(s_f[0]);
				mac_c = cr_q[0]; mac_dst = DST_CR0;
			end
			OP_S0: begin
				mac_a = cr_q[2]; mac_b = MB'(n_f[1]); mac_c = cr_q[1];
			end
			OP_S1: begin
				mac_a = acc_q; mac_b = MB'(n_f[0]); mac_c = cr_q[0];
			end
			OP_S2: begin
				mac_a = acc_q; mac_b = MB'(channels_q); mac_c = UW'(src_base_q);
			end
			OP_S3: begin
				mac_a = UW'(grp_idx_q); mac_b = MB'(cpg_q); mac_c = acc_q;
				mac_dst = DST_SRC;
			end
			OP_D0: begin
				mac_a = UW'(grp_idx_q); mac_b = MB'(k_f[2]); mac_c = UW'(tap_q[2]);
			end
			OP_D1: begin
				mac_a = acc_q; mac_b = MB'(k_f[1]); mac_c = UW'(tap_q[1]);
			end
			OP_D2: begin
				mac_a = acc_q; mac_b = MB'(k_f[0]); mac_c = UW'(tap_q[0]);
			end
			OP_D3: begin
				mac_a = acc_q; mac_b = MB'(cpg_q); mac_c = UW'(dst_base_q);
				mac_dst = DST_TMP;
			end
			OP_P0: begin
				mac_a = UW'(pos_q[2]); mac_b = MB'(ext_q[1]); mac_c = UW'(pos_q[1]);
			end
			OP_P1: begin
				mac_a = acc_q; mac_b = MB'(ext_q[0]); mac_c = UW'(pos_q[0]);
			end
			OP_P2: begin
				mac_a = acc_q; mac_b = MB'(k_f[2]);
			end
			OP_P3: begin
				mac_a = acc_q; mac_b = MB'(k_f[1]);
			end
			OP_P4: begin
				mac_a = acc_q; mac_b = MB'(k_f[0]);
			end
			OP_P5: begin
				mac_a = acc_q; mac_b = MB'(channels_q); mac_c = tmp_q;
			end
			OP_SPAN: begin
				// receptive span: dilation * (taps - 1), plus one
				mac_a = UW'(T'(k_f[axis_q] - 1'b1)); mac_b = MB'(d_f[axis_q]);
				mac_c = UW'(1);
			end
			default: begin
				mac_a = '0;
			end
		endcase
		mac_prod = mac_a * mac_b;
		mac_res  = mac_prod[UW-1:0] + mac_c;
	end

	// output extent numerator for the axis in work
	logic [SW-1:0]   ext_sum;
	logic [SW-1:0]   ext_span;
	logic            num_neg;
	logic [SW-1:0]   ext_num;

	always_comb begin
		ext_sum  = SW'(n_f[axis_q]) + SW'(pb_f[axis_q]) + SW'(pa_f[axis_q]);
		ext_span = SW'(acc_q[SPW-1:0]);
		num_neg  = ext_sum < ext_span;
		ext_num  = ext_sum - ext_span;
	end

	// serial divider, shared by extents and channels per group
	i2c3d_pkg::div_ctl_t div_ctl;
	i2c3d_pkg::div_sts_t div_sts;
	logic [DIVW-1:0]     div_num;
	logic [DVB-1:0]      div_den;
	logic [DIVW-1:0]     div_quo;
	logic                active_now;
	logic                ext_zero;

	assign ext_zero   = (k_f[axis_q] == '0) || num_neg;
	assign active_now = func_q ? run_active_q
		: ((ext_q[0] != '0) && (ext_q[1] != '0) && (ext_q[2] != '0));

	always_comb begin
		div_ctl.start = 1'b0;
		div_num       = DIVW'(channels_q);
		div_den       = DVB'(grp);
		if (state_q == S_NUM) begin
			div_ctl.start = !ext_zero;
			div_num       = DIVW'(ext_num);
			div_den       = DVB'(s_f[axis_q]);
		end else if (state_q == S_CHECK) begin
			div_ctl.start = active_now;
		end
	end

	i2c3d_div #(
		.NUM_BITS (DIVW),
		.DEN_BITS (DVB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_num),
		.divisor  (div_den),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	logic [E-1:0] ext_new;
	assign ext_new = (div_quo >= DIVW'(EXT_MAX)) ? EXT_MAX : E'(div_quo + 1'b1);

	// tap position test and walk advance
	logic         outside;
	logic [E-1:0] g_n;
	logic [T-1:0] tap_n [3];
	logic [E-1:0] pos_n [3];
	logic         fin;
	logic [E-1:0] g1;
	logic [T-1:0] t1 [3];
	logic [E-1:0] p1 [3];

	always_comb begin
		outside = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (cr_q[i][UW-1] || (cr_q[i] >= UW'(n_f[i]))) begin
				outside = 1'b1;
			end
			t1[i]    = tap_q[i] + 1'b1;
			p1[i]    = pos_q[i] + 1'b1;
			tap_n[i] = tap_q[i];
			pos_n[i] = pos_q[i];
		end
		g1  = grp_idx_q + 1'b1;
		g_n = g1;
		fin = 1'b0;
		if (GW'(g1) >= grp) begin
			g_n = '0;
			tap_n[0] = t1[0];
			if (!((t1[0] < k_f[0]) && (t1[0] != '0))) begin
				tap_n[0] = '0;
				tap_n[1] = t1[1];
				if (!((t1[1] < k_f[1]) && (t1[1] != '0))) begin
					tap_n[1] = '0;
					tap_n[2] = t1[2];
					if (!((t1[2] < k_f[2]) && (t1[2] != '0))) begin
						tap_n[2] = '0;
						pos_n[0] = p1[0];
						if (!((p1[0] < ext_q[0]) && (p1[0] != '0))) begin
							pos_n[0] = '0;
							pos_n[1] = p1[1];
							if (!((p1[1] < ext_q[1]) && (p1[1] != '0))) begin
								pos_n[1] = '0;
								pos_n[2] = p1[2];
								if (!((p1[2] < ext_q[2]) && (p1[2] != '0))) begin
									pos_n[2] = '0;
									fin = 1'b1;
								end
							end
						end
					end
				end
			end
		end
	end

	logic in_fire;
	logic out_free;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q <= i2c3d_pkg::CHANNELS_RST;
			groups_q   <= i2c3d_pkg::GROUPS_RST;
			image_q    <= i2c3d_pkg::IMAGE_RST;
			kernel_q   <= i2c3d_pkg::TRIPLE_ONE;
			dil_q      <= i2c3d_pkg::TRIPLE_ONE;
			stride_q   <= i2c3d_pkg::TRIPLE_ONE;
			padb_q     <= i2c3d_pkg::PAD_RST;
			pada_q     <= i2c3d_pkg::PAD_RST;
		end else if (cfg_wr_en) begin
			case (i2c3d_pkg::cfg_reg_t'(cfg_index))
				i2c3d_pkg::REG_CHANNELS:    channels_q <= cfg_data[CB-1:0];
				i2c3d_pkg::REG_GROUPS:      groups_q   <= cfg_data[CB-1:0];
				i2c3d_pkg::REG_IMAGE_SIZE:  image_q    <= cfg_data;
				i2c3d_pkg::REG_KERNEL_SIZE: kernel_q   <= cfg_data[i2c3d_pkg::PACK_BITS-1:0];
				i2c3d_pkg::REG_DILATION:    dil_q      <= cfg_data[i2c3d_pkg::PACK_BITS-1:0];
				i2c3d_pkg::REG_STRIDE:      stride_q   <= cfg_data[i2c3d_pkg::PACK_BITS-1:0];
				i2c3d_pkg::REG_PAD_BEFORE:  padb_q     <= cfg_data[i2c3d_pkg::PACK_BITS-1:0];
				i2c3d_pkg::REG_PAD_AFTER:   pada_q     <= cfg_data[i2c3d_pkg::PACK_BITS-1:0];
				default: channels_q <= channels_q;
			endcase
		end
	end

	// sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_CT0;
			axis_q       <= '0;
			run_active_q <= 1'b0;
			grp_idx_q    <= '0;
			m_valid_q    <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ext_q[i] <= '0;
				pos_q[i] <= '0;
				tap_q[i] <= '0;
			end
		end else begin
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (!s_axis_tdata[0]) begin
							axis_q    <= '0;
							grp_idx_q <= '0;
							for (int i = 0; i < 3; i++) begin
								pos_q[i] <= '0;
								tap_q[i] <= '0;
							end
							state_q <= S_SPAN;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_SPAN: begin
					state_q <= S_NUM;
				end
				S_NUM: begin
					if (ext_zero) begin
						ext_q[axis_q] <= '0;
						axis_q        <= axis_q + 1'b1;
						state_q       <= (axis_q == 2'd2) ? S_CHECK : S_SPAN;
					end else begin
						state_q <= S_EXTDIV;
					end
				end
				S_EXTDIV: begin
					if (div_sts.done) begin
						ext_q[axis_q] <= ext_new;
						axis_q        <= axis_q + 1'b1;
						state_q       <= (axis_q == 2'd2) ? S_CHECK : S_SPAN;
					end
				end
				S_CHECK: begin
					run_active_q <= active_now;
					state_q      <= active_now ? S_CPG : S_FIN;
				end
				S_CPG: begin
					if (div_sts.done) begin
						op_q    <= OP_CT0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					op_q <= op_q + 1'b1;
					if (op_q == OP_P5) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
						if (run_active_q) begin
							grp_idx_q <= g_n;
							for (int i = 0; i < 3; i++) begin
								pos_q[i] <= pos_n[i];
								tap_q[i] <= tap_n[i];
							end
							if (fin) begin
								run_active_q <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q     <= s_axis_tdata[0];
			src_base_q <= s_axis_tdata[A:1];
			dst_base_q <= s_axis_tdata[2*A:A+1];
		end
		if (state_q == S_CPG && div_sts.done) begin
			cpg_q <= LB'(div_quo);
		end
		if (state_q == S_SPAN || state_q == S_MAC) begin
			case (mac_dst)
				DST_ACC: acc_q    <= mac_res;
				DST_CR0: cr_q[0]  <= mac_res;
				DST_CR1: cr_q[1]  <= mac_res;
				DST_CR2: cr_q[2]  <= mac_res;
				DST_TMP: tmp_q    <= mac_res;
				DST_SRC: src_q    <= mac_res;
				default: acc_q    <= mac_res;
			endcase
		end
		if (state_q == S_FIN && out_free) begin
			if (run_active_q) begin
				m_src_q  <= outside ? '0 : src_q[A-1:0];
				m_dst_q  <= acc_q[A-1:0];
				m_len_q  <= cpg_q;
				m_fill_q <= outside;
				m_last_q <= fin;
				m_done_q <= 1'b0;
			end else begin
				m_src_q  <= '0;
				m_dst_q  <= '0;
				m_len_q  <= '0;
				m_fill_q <= 1'b0;
				m_last_q <= 1'b0;
				m_done_q <= 1'b1;
			end
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'({m_len_q, m_dst_q, m_src_q});
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = {m_done_q, m_fill_q};

endmodule

>>> tb/im2col_3d_checker.sv
// checker for the 3d im2col descriptor generator: tracks register writes and
// request transactions, predicts each descriptor and compares it on the output.
// depends on i2c3d_pkg for the register map and reset values
module im2col_3d_checker
	import i2c3d_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [71:0]              s_axis_tdata,
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [79:0]              m_axis_tdata,
	input  logic                     m_axis_tlast,
	input  logic [1:0]               m_axis_tuser,
	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [11:0] length;
		logic        fill_zero;
		logic        last;
		logic        done_res;
	} desc_t;

	desc_t descs_due[$];

	// register copies
	logic [11:0] r_chan, r_grp, r_kern, r_dil, r_strd, r_pb, r_pa;
	logic [35:0] r_img;

	// walk state
	logic [11:0] pos_t, pos_h, pos_w, grp_idx;
	logic [3:0]  tp_t, tp_h, tp_w;
	logic [35:0] extents;
	logic        active;

	assign pending = descs_due.size();

	function automatic longint img_dim(logic [35:0] v, int axis);
		return longint'(v[axis*12 +: 12]);
	endfunction

	function automatic longint nib(logic [11:0] v, int axis);
		return longint'(v[axis*4 +: 4]);
	endfunction

	function automatic longint group_count();
		return (r_grp == 0) ? 1 : longint'(r_grp);
	endfunction

	function automatic longint output_extent(int axis);
		longint n, k, d, s, num, e;
		n = img_dim(r_img, axis);
		k = nib(r_kern, axis);
		d = nib(r_dil, axis);
		s = nib(r_strd, axis);
		if (k == 0)
			return 0;
		if (s == 0)
			s = 1;
		num = n + nib(r_pb, axis) + nib(r_pa, axis) - (d * (k - 1) + 1);
		if (num < 0)
			return 0;
		e = num / s + 1;
		if (e > 4095)
			e = 4095;
		return e;
	endfunction

	function automatic longint tap_coord(int axis, longint pos, longint tap);
		longint s;
		s = nib(r_strd, axis);
		if (s == 0)
			s = 1;
		return pos * s - nib(r_pb, axis) + tap * nib(r_dil, axis);
	endfunction

	// steps the walk to the next descriptor, returns 1 when the run wraps
	function automatic bit step_walk();
		grp_idx = grp_idx + 1;
		if (grp_idx < group_count())
			return 0;
		grp_idx = 0;
		tp_w = tp_w + 1;
		if (tp_w < nib(r_kern, 0) && tp_w != 0)
			return 0;
		tp_w = 0;
		tp_h = tp_h + 1;
		if (tp_h < nib(r_kern, 1) && tp_h != 0)
			return 0;
		tp_h = 0;
		tp_t = tp_t + 1;
		if (tp_t < nib(r_kern, 2) && tp_t != 0)
			return 0;
		tp_t = 0;
		pos_w = pos_w + 1;
		if (pos_w < extents[11:0] && pos_w != 0)
			return 0;
		pos_w = 0;
		pos_h = pos_h + 1;
		if (pos_h < extents[23:12] && pos_h != 0)
			return 0;
		pos_h = 0;
		pos_t = pos_t + 1;
		if (pos_t < extents[35:24] && pos_t != 0)
			return 0;
		pos_t = 0;
		return 1;
	endfunction

	function automatic desc_t next_descriptor(logic func, logic [31:0] sb, logic [31:0] db);
		desc_t d;
		longint ew, eh, et, cpg, it, ih, iw, w, h, t, kw, kh, kt, pix, src, dst;
		bit outside;
		d = '{default: 0};
		if (func == 1'b0) begin
			ew = output_extent(0);
			eh = output_extent(1);
			et = output_extent(2);
			extents = {et[11:0], eh[11:0], ew[11:0]};
			{pos_t, pos_h, pos_w, grp_idx} = '0;
			{tp_t, tp_h, tp_w} = '0;
			active = ew != 0 && eh != 0 && et != 0;
		end
		if (!active) begin
			d.done_res = 1;
			return d;
		end
		w = img_dim(r_img, 0);
		h = img_dim(r_img, 1);
		t = img_dim(r_img, 2);
		kw = nib(r_kern, 0);
		kh = nib(r_kern, 1);
		kt = nib(r_kern, 2);
		cpg = longint'(r_chan) / group_count();
		it = tap_coord(2, pos_t, tp_t);
		ih = tap_coord(1, pos_h, tp_h);
		iw = tap_coord(0, pos_w, tp_w);
		outside = it < 0 || it >= t || ih < 0 || ih >= h || iw < 0 || iw >= w;
		src = 0;
		if (!outside)
			src = longint'(sb) + ((it * h + ih) * w + iw) * longint'(r_chan)
				+ longint'(grp_idx) * cpg;
		pix = (longint'(pos_t) * longint'(extents[23:12]) + pos_h)
			* longint'(extents[11:0]) + pos_w;
		dst = longint'(db) + pix * (kt * kh * kw * longint'(r_chan))
			+ (((longint'(grp_idx) * kt + tp_t) * kh + tp_h) * kw + tp_w) * cpg;
		d.src_addr = src[31:0];
		d.dst_addr = dst[31:0];
		d.length = cpg[11:0];
		d.fill_zero = outside;
		d.last = step_walk();
		if (d.last)
			active = 0;
		return d;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		desc_t want;
		if (!arst_n) begin
			r_chan <= CHANNELS_RST;
			r_grp  <= GROUPS_RST;
			r_img  <= IMAGE_RST;
			r_kern <= TRIPLE_ONE;
			r_dil  <= TRIPLE_ONE;
			r_strd <= TRIPLE_ONE;
			r_pb   <= PAD_RST;
			r_pa   <= PAD_RST;
			{pos_t, pos_h, pos_w, grp_idx} <= '0;
			{tp_t, tp_h, tp_w} <= '0;
			extents <= '0;
			active <= 0;
			descs_due.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_CHANNELS:    r_chan = cfg_data[11:0];
					REG_GROUPS:      r_grp  = cfg_data[11:0];
					REG_IMAGE_SIZE:  r_img  = cfg_data[35:0];
					REG_KERNEL_SIZE: r_kern = cfg_data[11:0];
					REG_DILATION:    r_dil  = cfg_data[11:0];
					REG_STRIDE:      r_strd = cfg_data[11:0];
					REG_PAD_BEFORE:  r_pb   = cfg_data[11:0];
					REG_PAD_AFTER:   r_pa   = cfg_data[11:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				descs_due.push_back(next_descriptor(s_axis_tdata[0], s_axis_tdata[32:1],
					s_axis_tdata[64:33]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (descs_due.size() == 0) begin
					report("unexpected descriptor", m_axis_tdata[31:0], 0);
				end else begin
					want = descs_due.pop_front();
					if (m_axis_tdata[31:0] !== want.src_addr)
						report("src_addr", m_axis_tdata[31:0], want.src_addr);
					if (m_axis_tdata[63:32] !== want.dst_addr)
						report("dst_addr", m_axis_tdata[63:32], want.dst_addr);
					if (m_axis_tdata[75:64] !== want.length)
						report("length", m_axis_tdata[75:64], want.length);
					if (m_axis_tuser[0] !== want.fill_zero)
						report("fill_zero", m_axis_tuser[0], want.fill_zero);
					if (m_axis_tlast !== want.last)
						report("last", m_axis_tlast, want.last);
					if (m_axis_tuser[1] !== want.done_res)
						report("done_res", m_axis_tuser[1], want.done_res);
				end
			end
		end
	end

endmodule

>>> tb/tb_im2col_3d_address_generator_core.sv
// top of the 3d im2col descriptor generator testbench: clock, reset, register
// programming and request stimulus; checking is done in im2col_3d_checker
// depends on i2c3d_pkg, im2col_3d_address_generator_core and im2col_3d_checker
module tb_im2col_3d_address_generator_core;
	import i2c3d_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FN_RESTART = 1'b0;
	localparam logic FN_NEXT    = 1'b1;
	localparam int   CYCLE_LIMIT = 2000000;
	localparam int   REQ_TARGET  = 750;

	logic                     clk = 0;
	logic                     arst_n = 0;
	logic                     cfg_wr_en = 0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     s_axis_tvalid = 0;
	logic                     s_axis_tready;
	logic [71:0]              s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 0;
	logic [79:0]              m_axis_tdata;
	logic                     m_axis_tlast;
	logic [1:0]               m_axis_tuser;
	int                       fail_count, pending;

	int  cycles = 0;
	int  reqs_sent = 0;
	bit  calm = 0;
	int  hold_asks = 0, hold_served = 0, hold_left = 0;
	logic [35:0] regv [8];

	im2col_3d_address_generator_core uut (.*);

	im2col_3d_checker chk (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_im2col_3d_address_generator_core failed");
			$finish;
		end
	end

	// output side: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= calm || $urandom_range(99) >= 11;
		end
	end

	// call at a rising edge; returns at the edge that accepted the request
	task automatic send(logic func, logic [31:0] sb, logic [31:0] db);
		if (!calm && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {7'b0, db, sb, func};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		reqs_sent++;
	endtask

	task automatic send_rand(logic func);
		send(func, $urandom, $urandom);
	endtask

	// drop the request and wait until every descriptor has come back
	task automatic drain();
		s_axis_tvalid <= 0;
		do @(negedge clk); while (pending != 0);
		repeat (120) @(posedge clk);
	endtask

	// writes all eight registers back to back, one per cycle
	task automatic program_regs();
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= regv[i];
			@(posedge clk);
		end
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	function automatic logic [35:0] pack12(logic [11:0] v);
		return {24'($urandom_range(16777215, 0)), v};
	endfunction

	function automatic logic [11:0] triple(int lo, int hi);
		return {4'($urandom_range(hi, lo)), 4'($urandom_range(hi, lo)),
			4'($urandom_range(hi, lo))};
	endfunction

	function automatic logic [11:0] dim(int hi);
		return ($urandom_range(99) < 3) ? 12'($urandom) : 12'($urandom_range(hi, 0));
	endfunction

	task automatic random_regs();
		logic [11:0] k;
		regv[REG_CHANNELS] = pack12(($urandom_range(1) == 0) ? 12'($urandom_range(4095, 1))
			: 12'($urandom_range(16, 1)));
		regv[REG_GROUPS] = pack12(($urandom_range(99) < 3) ? 12'($urandom)
			: 12'($urandom_range(4, 0)));
		regv[REG_IMAGE_SIZE] = {dim(6), dim(6), dim(6)};
		k = triple(1, 3);
		if ($urandom_range(99) < 5)
			k[4 * $urandom_range(2) +: 4] = 0;
		regv[REG_KERNEL_SIZE] = pack12(k);
		regv[REG_DILATION] = pack12(triple(0, 2));
		regv[REG_STRIDE] = pack12(triple(0, 3));
		regv[REG_PAD_BEFORE] = pack12(triple(0, 2));
		regv[REG_PAD_AFTER] = pack12(triple(0, 2));
	endtask

	task automatic set_regs(logic [11:0] ch, logic [11:0] gr, logic [35:0] img,
		logic [11:0] ks, logic [11:0] dl, logic [11:0] st, logic [11:0] pb, logic [11:0] pa);
		regv = '{36'(ch), 36'(gr), img, 36'(ks), 36'(dl), 36'(st), 36'(pb), 36'(pa)};
		program_regs();
	endtask

	initial begin
		int phase, n;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// no run yet, then the one-pixel default run
		send_rand(FN_NEXT);
		send_rand(FN_RESTART);
		send_rand(FN_NEXT);
		drain();

		// zero groups, padding before on every axis
		set_regs(12'd4095, 12'd0, 36'h002002002, 12'h222, 12'h111, 12'h111,
			12'h111, 12'h000);
		send(FN_RESTART, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send(FN_NEXT, 32'h0, 32'h0);
		repeat (3) send_rand(FN_NEXT);
		drain();

		// every field but groups at its top, groups not dividing channels
		set_regs(12'd4095, 12'd2, 36'hFFFFFFFFF, 12'hFFF, 12'hFFF, 12'hFFF,
			12'hFFF, 12'hFFF);
		send_rand(FN_RESTART);
		repeat (3) send_rand(FN_NEXT);
		drain();

		// zero stride on a full image: extents saturate
		set_regs(12'd7, 12'd3, 36'hFFFFFFFFF, 12'h111, 12'h111, 12'h000,
			12'hFFF, 12'hFFF);
		send_rand(FN_RESTART);
		repeat (2) send_rand(FN_NEXT);
		drain();

		// zero dilation: taps repeat the same pixel
		set_regs(12'd2, 12'd1, 36'h002003003, 12'h333, 12'h000, 12'h111,
			12'h000, 12'h000);
		send_rand(FN_RESTART);
		repeat (3) send_rand(FN_NEXT);
		drain();

		// zero kernel and a kernel wider than the image: both empty
		set_regs(12'd1, 12'd1, 36'h004004004, 12'h101, 12'h111, 12'h111,
			12'h000, 12'h000);
		send_rand(FN_RESTART);
		drain();
		set_regs(12'd1, 12'd1, 36'h001001001, 12'h333, 12'h222, 12'h111,
			12'h000, 12'h000);
		send_rand(FN_RESTART);
		send_rand(FN_NEXT);
		drain();

		phase = 0;
		while (reqs_sent < REQ_TARGET) begin
			random_regs();
			program_regs();
			calm = phase >= 6 && phase < 10;
			if ($urandom_range(99) < 85)
				send_rand(FN_RESTART);
			if (phase == 3 || phase == 20)
				hold_asks++;
			n = $urandom_range(40, 5);
			repeat (n)
				send_rand(($urandom_range(99) < 8) ? FN_RESTART : FN_NEXT);
			drain();
			phase++;
		end
		calm = 0;

		if (fail_count == 0) begin
			$display("tb_im2col_3d_address_generator_core passed");
		end else begin
			$display("tb_im2col_3d_address_generator_core failed");
		end
		$finish;
	end

endmodule
